@@ design/csd_pkg.sv @@
// Package for the cyclic slot task dispatcher.
// Holds the beat types, codes, command and status structs shared by all modules.
// Depends on nothing.
`default_nettype none

package csd_pkg;

	localparam int NUM_SLOTS_DEF      = 16;
	localparam int TASKS_PER_SLOT_DEF = 8;

	localparam logic OP_CREATE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	localparam logic KIND_CREATE   = 1'b0;
	localparam logic KIND_DISPATCH = 1'b1;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_ZERO_PERIOD = 2'd1;
	localparam logic [1:0] ST_SLOT_FULL   = 2'd2;

	typedef struct packed {
		logic       opcode;
		logic [7:0] task_id;
		logic [7:0] priority_req;
		logic [7:0] period;
	} in_beat_t;

	typedef struct packed {
		logic       kind;
		logic [1:0] status;
		logic       task_valid;
		logic [7:0] dispatched_id;
		logic [3:0] slot_index;
		logic       last;
	} out_beat_t;

	typedef struct packed {
		logic [7:0] id;
		logic [7:0] prio;
	} entry_t;

	typedef enum logic [1:0] {
		EMIT_NONE,
		EMIT_STATUS,
		EMIT_TASK,
		EMIT_EMPTY
	} emit_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_CHECK,
		S_INS_START,
		S_INS_CMP,
		S_INS_WRITE,
		S_EMIT_STATUS,
		S_TICK_RD,
		S_TICK_EMIT,
		S_EMIT_EMPTY
	} state_t;

	typedef struct packed {
		logic       load_in;
		logic       step_s;
		logic       clr_s;
		logic       set_status;
		logic [1:0] status;
		logic       load_k;
		logic       shift;
		logic       ins_write;
		logic       tick_read;
		emit_t      emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_tick;
		logic period_zero;
		logic slot_done;
		logic slot_full;
		logic cnt_zero;
		logic k_one;
		logic less;
		logic out_free;
		logic tick_empty;
		logic tick_last;
	} dp_stat_t;

endpackage

`default_nettype wire

@@ design/cyclic_slot_task_dispatcher.sv @@
// Top level of the cyclic slot task dispatcher.
// Joins csd_ctrl and csd_datapath; uses csd_pkg.
//
// The block takes one input beat at a time and answers through a registered
// output beat. A tick passes through decode and then, for each dispatched task,
// a table read followed by an output load, or a single output load for an empty
// slot, and is held by any output stall. A create passes through decode and, for
// a zero period, then loads its status. Otherwise it steps through each chosen
// slot in the fullness check, then for each chosen slot starts the insert,
// compares table entries with the new priority one at a time, shifting each
// lower one up, and writes; then it ends the walk and loads the status. The walk
// reads one table entry per cycle. The next input beat is taken in the cycle
// after the previous result has been loaded into the output register.
`default_nettype none

module cyclic_slot_task_dispatcher #(
	parameter int NUM_SLOTS      = csd_pkg::NUM_SLOTS_DEF,
	parameter int TASKS_PER_SLOT = csd_pkg::TASKS_PER_SLOT_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire csd_pkg::in_beat_t   in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output csd_pkg::out_beat_t       out_data
);

	csd_pkg::ctrl_cmd_t cmd;
	csd_pkg::dp_stat_t  stat;

	csd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	csd_datapath #(
		.NUM_SLOTS      (NUM_SLOTS),
		.TASKS_PER_SLOT (TASKS_PER_SLOT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

@@ design/csd_ctrl.sv @@
// Controller state machine of the cyclic slot task dispatcher.
// Sequences create and tick items through the datapath; uses csd_pkg.
`default_nettype none

module csd_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire csd_pkg::dp_stat_t   stat,
	output csd_pkg::ctrl_cmd_t       cmd
);

	csd_pkg::state_t state_q;
	csd_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csd_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.emit = csd_pkg::EMIT_NONE;
		case (state_q)
			csd_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = csd_pkg::S_DECODE;
				end
			end
			csd_pkg::S_DECODE: begin
				if (stat.is_tick) begin
					state_d = stat.tick_empty ? csd_pkg::S_EMIT_EMPTY : csd_pkg::S_TICK_RD;
				end else if (stat.period_zero) begin
					cmd.set_status = 1'b1;
					cmd.status     = csd_pkg::ST_ZERO_PERIOD;
					state_d        = csd_pkg::S_EMIT_STATUS;
				end else begin
					state_d = csd_pkg::S_CHECK;
				end
			end
			csd_pkg::S_CHECK: begin
				if (stat.slot_done) begin
					cmd.clr_s = 1'b1;
					state_d   = csd_pkg::S_INS_START;
				end else if (stat.slot_full) begin
					cmd.set_status = 1'b1;
					cmd.status     = csd_pkg::ST_SLOT_FULL;
					state_d        = csd_pkg::S_EMIT_STATUS;
				end else begin
					cmd.step_s = 1'b1;
				end
			end
			csd_pkg::S_INS_START: begin
				if (stat.slot_done) begin
					cmd.set_status = 1'b1;
					cmd.status     = csd_pkg::ST_OK;
					state_d        = csd_pkg::S_EMIT_STATUS;
				end else begin
					cmd.load_k = 1'b1;
					state_d    = stat.cnt_zero ? csd_pkg::S_INS_WRITE : csd_pkg::S_INS_CMP;
				end
			end
			csd_pkg::S_INS_CMP: begin
				if (stat.less) begin
					cmd.shift = 1'b1;
					if (stat.k_one) begin
						state_d = csd_pkg::S_INS_WRITE;
					end
				end else begin
					state_d = csd_pkg::S_INS_WRITE;
				end
			end
			csd_pkg::S_INS_WRITE: begin
				cmd.ins_write = 1'b1;
				cmd.step_s    = 1'b1;
				state_d       = csd_pkg::S_INS_START;
			end
			csd_pkg::S_EMIT_STATUS: begin
				if (stat.out_free) begin
					cmd.emit = csd_pkg::EMIT_STATUS;
					state_d  = csd_pkg::S_IDLE;
				end
			end
			csd_pkg::S_TICK_RD: begin
				cmd.tick_read = 1'b1;
				state_d       = csd_pkg::S_TICK_EMIT;
			end
			csd_pkg::S_TICK_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = csd_pkg::EMIT_TASK;
					state_d  = stat.tick_last ? csd_pkg::S_IDLE : csd_pkg::S_TICK_RD;
				end
			end
			csd_pkg::S_EMIT_EMPTY: begin
				if (stat.out_free) begin
					cmd.emit = csd_pkg::EMIT_EMPTY;
					state_d  = csd_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = csd_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ design/csd_datapath.sv @@
// Datapath of the cyclic slot task dispatcher: slot table memory, slot counts,
// walk registers and the output register. Uses csd_pkg.
`default_nettype none

module csd_datapath #(
	parameter int NUM_SLOTS      = csd_pkg::NUM_SLOTS_DEF,
	parameter int TASKS_PER_SLOT = csd_pkg::TASKS_PER_SLOT_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire csd_pkg::in_beat_t   in_data,
	input  wire csd_pkg::ctrl_cmd_t  cmd,
	output csd_pkg::dp_stat_t        stat,
	input  wire logic                out_ready,
	output logic                     out_valid,
	output csd_pkg::out_beat_t       out_data
);

	localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int JW    = (TASKS_PER_SLOT > 1) ? $clog2(TASKS_PER_SLOT) : 1;
	localparam int CW    = $clog2(TASKS_PER_SLOT + 1);
	localparam int SCW   = $clog2(NUM_SLOTS + 256);
	localparam int AW    = SW + JW;
	localparam int DEPTH = NUM_SLOTS * (2 ** JW);

	logic             op_q;
	logic [7:0]       id_q;
	logic [7:0]       prio_q;
	logic [7:0]       period_q;
	logic [SCW-1:0]   s_q;
	logic [CW-1:0]    k_q;
	logic [CW-1:0]    i_q;
	logic [SW-1:0]    cur_q;
	logic [1:0]       status_q;
	logic [CW-1:0]    counts_q [NUM_SLOTS];
	csd_pkg::entry_t  mem [DEPTH];
	csd_pkg::entry_t  rdata_q;
	csd_pkg::out_beat_t out_q;
	logic             out_valid_q;

	logic [SW-1:0]    slot_sel;
	logic [CW-1:0]    cnt_s;
	logic [CW-1:0]    cnt_cur;
	logic             tick_last;
	logic             out_free;
	logic             we;
	logic             re;
	logic [AW-1:0]    waddr;
	logic [AW-1:0]    raddr;
	csd_pkg::entry_t  wdata;
	csd_pkg::out_beat_t out_next;

	assign slot_sel  = s_q[SW-1:0];
	assign cnt_s     = counts_q[slot_sel];
	assign cnt_cur   = counts_q[cur_q];
	assign tick_last = (i_q == cnt_cur - CW'(1));
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		stat.is_tick     = (op_q == csd_pkg::OP_TICK);
		stat.period_zero = (period_q == 8'd0);
		stat.slot_done   = (s_q >= SCW'(NUM_SLOTS));
		stat.slot_full   = (cnt_s >= CW'(TASKS_PER_SLOT));
		stat.cnt_zero    = (cnt_s == '0);
		stat.k_one       = (k_q == CW'(1));
		stat.less        = (rdata_q.prio < prio_q);
		stat.out_free    = out_free;
		stat.tick_empty  = (cnt_cur == '0);
		stat.tick_last   = tick_last;
	end

	assign we    = cmd.shift || cmd.ins_write;
	assign waddr = {slot_sel, k_q[JW-1:0]};
	assign wdata = cmd.shift ? rdata_q : csd_pkg::entry_t'({id_q, prio_q});
	assign re    = cmd.load_k || cmd.shift || cmd.tick_read;

	always_comb begin
		if (cmd.tick_read) begin
			raddr = {cur_q, i_q[JW-1:0]};
		end else if (cmd.load_k) begin
			raddr = {slot_sel, JW'(cnt_s - CW'(1))};
		end else begin
			raddr = {slot_sel, JW'(k_q - CW'(2))};
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q     <= in_data.opcode;
			id_q     <= in_data.task_id;
			prio_q   <= in_data.priority_req;
			period_q <= in_data.period;
		end
		if (cmd.set_status) begin
			status_q <= cmd.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q   <= '0;
			k_q   <= '0;
			i_q   <= '0;
			cur_q <= '0;
			for (int n = 0; n < NUM_SLOTS; n++) begin
				counts_q[n] <= '0;
			end
		end else begin
			if (cmd.load_in || cmd.clr_s) begin
				s_q <= '0;
			end else if (cmd.step_s) begin
				s_q <= s_q + SCW'(period_q);
			end
			if (cmd.load_k) begin
				k_q <= cnt_s;
			end else if (cmd.shift) begin
				k_q <= k_q - CW'(1);
			end
			if (cmd.ins_write) begin
				counts_q[slot_sel] <= cnt_s + CW'(1);
			end
			if (cmd.load_in) begin
				i_q <= '0;
			end else if (cmd.emit == csd_pkg::EMIT_TASK) begin
				i_q <= i_q + CW'(1);
			end
			if ((cmd.emit == csd_pkg::EMIT_EMPTY) ||
			    ((cmd.emit == csd_pkg::EMIT_TASK) && tick_last)) begin
				cur_q <= (cur_q == SW'(NUM_SLOTS - 1)) ? '0 : cur_q + SW'(1);
			end
		end
	end

	always_comb begin
		out_next = '0;
		case (cmd.emit)
			csd_pkg::EMIT_STATUS: begin
				out_next.kind   = csd_pkg::KIND_CREATE;
				out_next.status = status_q;
				out_next.last   = 1'b1;
			end
			csd_pkg::EMIT_TASK: begin
				out_next.kind          = csd_pkg::KIND_DISPATCH;
				out_next.status        = csd_pkg::ST_OK;
				out_next.task_valid    = 1'b1;
				out_next.dispatched_id = rdata_q.id;
				out_next.slot_index    = 4'(cur_q);
				out_next.last          = tick_last;
			end
			csd_pkg::EMIT_EMPTY: begin
				out_next.kind       = csd_pkg::KIND_DISPATCH;
				out_next.status     = csd_pkg::ST_OK;
				out_next.slot_index = 4'(cur_q);
				out_next.last       = 1'b1;
			end
			default: begin
				out_next = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit != csd_pkg::EMIT_NONE) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit != csd_pkg::EMIT_NONE) begin
			out_q <= out_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire
